[src/url_component_splitter_assert.svh]
// Assertion macros shared by the URL splitter checker.
// Each macro samples on clk; the reset-qualified forms use rst.
`ifndef URL_COMPONENT_SPLITTER_ASSERT_SVH
`define URL_COMPONENT_SPLITTER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define USP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("url_component_splitter: assertion failed");

// Next-cycle implication, off during reset.
`define USP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("url_component_splitter: assertion failed");

// Next-cycle implication that also covers reset itself.
`define USP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("url_component_splitter: assertion failed");

`endif

[src/usp_pkg.sv]
// Package for the URL component splitter: sizes, byte classes, result record.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package usp_pkg;

  localparam int MAX_URL_LEN = 4096;
  localparam int POS_W = 12;
  localparam int POS_CAP_I = ((MAX_URL_LEN - 1) < 4095) ? (MAX_URL_LEN - 1) : 4095;
  localparam logic [POS_W-1:0] POS_CAP = POS_CAP_I[POS_W-1:0];

  localparam int CH_W = 8;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_END = 8'h00;

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_SLASH,
    CLS_COLON,
    CLS_END
  } cls_t;

  typedef struct packed {
    logic valid;
    cls_t cls;
  } cls_beat_t;

  typedef struct packed {
    logic             has_scheme;
    logic             has_domain;
    logic             has_port_part;
    logic             has_path_part;
    logic [POS_W-1:0] scheme_len;
    logic [POS_W-1:0] domain_start;
    logic [POS_W-1:0] domain_len;
    logic [POS_W-1:0] port_start;
    logic [POS_W-1:0] port_len;
    logic [POS_W-1:0] path_start;
    logic [POS_W-1:0] path_len;
    logic             overflow;
  } res_t;

endpackage

`default_nettype wire

[src/usp_front.sv]
// Front stage: accepts URL bytes and registers their class.
// Depends on usp_pkg.
`default_nettype none

module usp_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [usp_pkg::CH_W-1:0] ch,
  output usp_pkg::cls_beat_t            beat,
  input  wire logic                     beat_ready
);
  import usp_pkg::*;

  cls_t cls_in;
  logic take;

  always_comb begin
    if (ch == CH_SLASH) begin
      cls_in = CLS_SLASH;
    end else if (ch == CH_COLON) begin
      cls_in = CLS_COLON;
    end else if (ch == CH_END) begin
      cls_in = CLS_END;
    end else begin
      cls_in = CLS_OTHER;
    end
  end

  assign in_ready = !beat.valid || beat_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (in_ready) begin
      beat.valid <= in_valid;
    end
    if (take) begin
      beat.cls <= cls_in;
    end
  end

endmodule

`default_nettype wire

[src/usp_queue.sv]
// Short class queue between the front stage and the parser.
// Depends on usp_pkg.
`default_nettype none

module usp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire usp_pkg::cls_beat_t in_beat,
  output logic                    in_ready,
  output usp_pkg::cls_beat_t      out_beat,
  input  wire logic               out_ready
);
  import usp_pkg::*;

  cls_t              slots [QUEUE_DEPTH];
  logic [QA_W-1:0]   wr_ptr;
  logic [QA_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready = (count != QUEUE_FULL);
  assign push = in_beat.valid && in_ready;
  assign pop = out_beat.valid && out_ready;
  assign out_beat.valid = (count != '0);
  assign out_beat.cls = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= in_beat.cls;
    end
  end

endmodule

`default_nettype wire

[src/usp_back.sv]
// Back stage: parse-mode machine over byte classes and the result register.
// Depends on usp_pkg.
`default_nettype none

module usp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire usp_pkg::cls_beat_t beat,
  output logic                    beat_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output usp_pkg::res_t           res
);
  import usp_pkg::*;

  typedef enum logic [2:0] {
    M_SCHEME,
    M_COLON,
    M_COLON_SLASH,
    M_DOMAIN,
    M_PORT,
    M_PATH
  } mode_t;

  function automatic logic [POS_W-1:0] sat(input logic [POS_W:0] v);
    return (v > {1'b0, POS_CAP}) ? POS_CAP : v[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] b,
                                            input logic [POS_W-1:0] e);
    return (e > b) ? (e - b) : '0;
  endfunction

  mode_t            mode, mode_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] colon_pos, colon_pos_next;
  logic [POS_W-1:0] dom_begin, dom_begin_next;
  logic [POS_W-1:0] dom_end, dom_end_next;
  logic [POS_W-1:0] port_begin, port_begin_next;
  logic [POS_W-1:0] port_end, port_end_next;
  logic [POS_W-1:0] path_begin, path_begin_next;
  logic             f_scheme, f_scheme_next;
  logic             f_domain, f_domain_next;
  logic             f_port, f_port_next;
  logic             f_path, f_path_next;
  logic             f_ovf, f_ovf_next;
  logic             done;
  logic             again;
  logic             consume;
  logic [POS_W:0]   pos_w;
  logic [POS_W:0]   col_w;
  res_t             res_d;

  assign pos_w = {1'b0, pos};
  assign col_w = {1'b0, colon_pos};
  assign consume = beat.valid && ((beat.cls != CLS_END) || !out_valid || out_ready);
  assign beat_ready = consume;

  always_comb begin
    mode_next = mode;
    pos_next = pos;
    colon_pos_next = colon_pos;
    dom_begin_next = dom_begin;
    dom_end_next = dom_end;
    port_begin_next = port_begin;
    port_end_next = port_end;
    path_begin_next = path_begin;
    f_scheme_next = f_scheme;
    f_domain_next = f_domain;
    f_port_next = f_port;
    f_path_next = f_path;
    f_ovf_next = f_ovf;
    done = 1'b0;
    again = 1'b0;

    case (mode)
      M_SCHEME: begin
        case (beat.cls)
          CLS_SLASH: begin
            f_domain_next = 1'b1;
            dom_end_next = pos;
            path_begin_next = sat(pos_w + 1'b1);
            mode_next = M_PATH;
          end
          CLS_COLON: begin
            colon_pos_next = pos;
            mode_next = M_COLON;
          end
          CLS_END: begin
            f_domain_next = 1'b1;
            dom_end_next = pos;
            done = 1'b1;
          end
          default: ;
        endcase
      end
      M_COLON: begin
        if (beat.cls == CLS_SLASH) begin
          mode_next = M_COLON_SLASH;
        end else begin
          f_domain_next = 1'b1;
          f_port_next = 1'b1;
          dom_end_next = colon_pos;
          port_begin_next = sat(col_w + 1'b1);
          mode_next = M_PORT;
          again = 1'b1;
        end
      end
      M_COLON_SLASH: begin
        if (beat.cls == CLS_SLASH) begin
          f_scheme_next = 1'b1;
          dom_begin_next = sat(col_w + 2'd3);
          mode_next = M_DOMAIN;
        end else begin
          f_domain_next = 1'b1;
          f_port_next = 1'b1;
          dom_end_next = colon_pos;
          port_begin_next = sat(col_w + 1'b1);
          port_end_next = sat(col_w + 1'b1);
          path_begin_next = sat(col_w + 2'd2);
          mode_next = M_PATH;
          again = 1'b1;
        end
      end
      M_DOMAIN: begin
        case (beat.cls)
          CLS_COLON: begin
            f_domain_next = 1'b1;
            f_port_next = 1'b1;
            dom_end_next = pos;
            port_begin_next = sat(pos_w + 1'b1);
            mode_next = M_PORT;
          end
          CLS_SLASH: begin
            f_domain_next = 1'b1;
            dom_end_next = pos;
            path_begin_next = sat(pos_w + 1'b1);
            mode_next = M_PATH;
          end
          CLS_END: begin
            f_domain_next = 1'b1;
            dom_end_next = pos;
            done = 1'b1;
          end
          default: ;
        endcase
      end
      M_PORT: begin
        if (beat.cls == CLS_SLASH) begin
          port_end_next = pos;
          path_begin_next = sat(pos_w + 1'b1);
          mode_next = M_PATH;
        end else if (beat.cls == CLS_END) begin
          port_end_next = pos;
          done = 1'b1;
        end
      end
      default: begin
        if (beat.cls == CLS_END) begin
          done = 1'b1;
        end else begin
          f_path_next = 1'b1;
        end
      end
    endcase

    // Replay the byte in the mode the colon look-ahead resolved to.
    if (again) begin
      case (mode_next)
        M_PORT: begin
          if (beat.cls == CLS_SLASH) begin
            port_end_next = pos;
            path_begin_next = sat(pos_w + 1'b1);
            mode_next = M_PATH;
          end else if (beat.cls == CLS_END) begin
            port_end_next = pos;
            done = 1'b1;
          end
        end
        default: begin
          if (beat.cls == CLS_END) begin
            done = 1'b1;
          end else begin
            f_path_next = 1'b1;
          end
        end
      endcase
    end

    res_d.has_scheme = f_scheme_next;
    res_d.has_domain = f_domain_next;
    res_d.has_port_part = f_port_next;
    res_d.has_path_part = f_path_next;
    res_d.scheme_len = f_scheme_next ? colon_pos_next : '0;
    res_d.domain_start = dom_begin_next;
    res_d.domain_len = span(dom_begin_next, dom_end_next);
    res_d.port_start = f_port_next ? port_begin_next : '0;
    res_d.port_len = f_port_next ? span(port_begin_next, port_end_next) : '0;
    res_d.path_start = f_path_next ? path_begin_next : '0;
    res_d.path_len = f_path_next ? span(path_begin_next, pos) : '0;
    res_d.overflow = f_ovf_next;

    if (!done) begin
      if (pos >= POS_CAP) begin
        f_ovf_next = 1'b1;
      end else begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && done)) begin
      mode <= M_SCHEME;
      pos <= '0;
      colon_pos <= '0;
      dom_begin <= '0;
      dom_end <= '0;
      port_begin <= '0;
      port_end <= '0;
      path_begin <= '0;
      f_scheme <= 1'b0;
      f_domain <= 1'b0;
      f_port <= 1'b0;
      f_path <= 1'b0;
      f_ovf <= 1'b0;
    end else if (consume) begin
      mode <= mode_next;
      pos <= pos_next;
      colon_pos <= colon_pos_next;
      dom_begin <= dom_begin_next;
      dom_end <= dom_end_next;
      port_begin <= port_begin_next;
      port_end <= port_end_next;
      path_begin <= path_begin_next;
      f_scheme <= f_scheme_next;
      f_domain <= f_domain_next;
      f_port <= f_port_next;
      f_path <= f_path_next;
      f_ovf <= f_ovf_next;
    end

    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (consume && done) begin
      res <= res_d;
    end
  end

endmodule

`default_nettype wire

[src/url_component_splitter.sv]
// Top level of the URL component splitter: front stage, class queue, parser.
// Depends on usp_pkg, usp_front, usp_queue and usp_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | ch: one URL byte per beat, zero ends URL
//   output  | out_valid/ out_ready | presence flags, offsets, lengths, overflow
//
// One byte per cycle sustained while no output stall holds a terminator; the parse-mode update in usp_back sets it.
// A terminator beat passes the front register and the class queue before the parser registers its result.
// Output stalls reach the parser only at a terminator; other bytes keep
// flowing through the four-entry queue.
// Synchronous reset clears the front stage, the queue, the parser and the output valid flag.
`default_nettype none

module url_component_splitter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [usp_pkg::CH_W-1:0]  ch,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           has_scheme,
  output logic                           has_domain,
  output logic                           has_port_part,
  output logic                           has_path_part,
  output logic [usp_pkg::POS_W-1:0]      scheme_len,
  output logic [usp_pkg::POS_W-1:0]      domain_start,
  output logic [usp_pkg::POS_W-1:0]      domain_len,
  output logic [usp_pkg::POS_W-1:0]      port_start,
  output logic [usp_pkg::POS_W-1:0]      port_len,
  output logic [usp_pkg::POS_W-1:0]      path_start,
  output logic [usp_pkg::POS_W-1:0]      path_len,
  output logic                           overflow
);
  import usp_pkg::*;

  cls_beat_t front_beat;
  logic      front_ready;
  cls_beat_t queue_beat;
  logic      queue_ready;
  res_t      res;

  usp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .beat       (front_beat),
    .beat_ready (front_ready)
  );

  usp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (front_beat),
    .in_ready  (front_ready),
    .out_beat  (queue_beat),
    .out_ready (queue_ready)
  );

  usp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .beat       (queue_beat),
    .beat_ready (queue_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign has_scheme = res.has_scheme;
  assign has_domain = res.has_domain;
  assign has_port_part = res.has_port_part;
  assign has_path_part = res.has_path_part;
  assign scheme_len = res.scheme_len;
  assign domain_start = res.domain_start;
  assign domain_len = res.domain_len;
  assign port_start = res.port_start;
  assign port_len = res.port_len;
  assign path_start = res.path_start;
  assign path_len = res.path_len;
  assign overflow = res.overflow;

endmodule

`default_nettype wire

[src/usp_checker.sv]
// Port-level checker for url_component_splitter, bound to the top level.
// Depends on url_component_splitter_assert.svh.
`default_nettype none

`include "url_component_splitter_assert.svh"

module usp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        has_scheme,
  input wire logic        has_domain,
  input wire logic        has_path_part,
  input wire logic [11:0] scheme_len,
  input wire logic [11:0] domain_start,
  input wire logic [11:0] path_start,
  input wire logic [11:0] path_len
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `USP_ASSERT_RST(a_reset_idle, rst, !out_valid && in_ready)
  `USP_ASSERT_IMPL(a_domain_always, out_valid, has_domain)
  `USP_ASSERT_IMPL(a_no_scheme_len, out_valid && !has_scheme, scheme_len == '0)
  `USP_ASSERT_IMPL(a_no_path_zero, out_valid && !has_path_part, path_start == '0 && path_len == '0)
  `USP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(domain_start) && $stable(path_len))

endmodule

bind url_component_splitter usp_checker u_usp_checker (.*);

`default_nettype wire

[test/tb_url_component_splitter.sv]
// Self-checking testbench for url_component_splitter: streams URL bytes and
// checks each parse result against a cycle-free model of the parser.
// Depends on usp_pkg and the RTL of the block only.
`default_nettype none

module tb_url_component_splitter;
  import usp_pkg::*;

  typedef logic [POS_W-1:0] pos_t;
  typedef enum logic [2:0] {
    PM_SCHEME,
    PM_COLON,
    PM_COLON_SLASH,
    PM_DOMAIN,
    PM_PORT,
    PM_PATH
  } parse_mode_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_BYTES = 450;

  class url_scoreboard;
    parse_mode_t mode;
    pos_t pos, colon_pos, dom_b, dom_e, port_b, port_e, path_b;
    bit f_scheme, f_domain, f_port, f_path, f_ovf;
    res_t pending[$];
    int errors;
    int n_checked;
    int n_overflow;

    function new();
      errors = 0;
      n_checked = 0;
      n_overflow = 0;
      restart();
    endfunction

    function void restart();
      mode = PM_SCHEME;
      pos = '0;
      colon_pos = '0;
      dom_b = '0;
      dom_e = '0;
      port_b = '0;
      port_e = '0;
      path_b = '0;
      {f_scheme, f_domain, f_port, f_path, f_ovf} = '0;
    endfunction

    function pos_t clamp(int v);
      return (v > POS_CAP_I) ? POS_CAP : pos_t'(v);
    endfunction

    function pos_t span_len(pos_t b, pos_t e);
      return (e > b) ? pos_t'(e - b) : '0;
    endfunction

    function void note_byte(logic [CH_W-1:0] c);
      bit again;
      bit done;
      int pass;
      res_t r;
      done = 0;
      for (pass = 0; pass < 2; pass++) begin
        again = 0;
        case (mode)
          PM_SCHEME: begin
            if (c == CH_SLASH) begin
              f_domain = 1;
              dom_e = pos;
              path_b = clamp(int'(pos) + 1);
              mode = PM_PATH;
            end else if (c == CH_COLON) begin
              colon_pos = pos;
              mode = PM_COLON;
            end else if (c == CH_END) begin
              f_domain = 1;
              dom_e = pos;
              done = 1;
            end
          end
          PM_COLON: begin
            if (c == CH_SLASH) begin
              mode = PM_COLON_SLASH;
            end else begin
              f_domain = 1;
              f_port = 1;
              dom_e = colon_pos;
              port_b = clamp(int'(colon_pos) + 1);
              mode = PM_PORT;
              again = 1;
            end
          end
          PM_COLON_SLASH: begin
            if (c == CH_SLASH) begin
              f_scheme = 1;
              dom_b = clamp(int'(colon_pos) + 3);
              mode = PM_DOMAIN;
            end else begin
              f_domain = 1;
              f_port = 1;
              dom_e = colon_pos;
              port_b = clamp(int'(colon_pos) + 1);
              port_e = port_b;
              path_b = clamp(int'(colon_pos) + 2);
              mode = PM_PATH;
              again = 1;
            end
          end
          PM_DOMAIN: begin
            if (c == CH_COLON) begin
              f_domain = 1;
              f_port = 1;
              dom_e = pos;
              port_b = clamp(int'(pos) + 1);
              mode = PM_PORT;
            end else if (c == CH_SLASH) begin
              f_domain = 1;
              dom_e = pos;
              path_b = clamp(int'(pos) + 1);
              mode = PM_PATH;
            end else if (c == CH_END) begin
              f_domain = 1;
              dom_e = pos;
              done = 1;
            end
          end
          PM_PORT: begin
            if (c == CH_SLASH) begin
              port_e = pos;
              path_b = clamp(int'(pos) + 1);
              mode = PM_PATH;
            end else if (c == CH_END) begin
              port_e = pos;
              done = 1;
            end
          end
          default: begin
            if (c == CH_END) done = 1;
            else f_path = 1;
          end
        endcase
        if (!again) break;
      end

      if (!done) begin
        if (pos >= POS_CAP) f_ovf = 1;
        else pos = pos + 1'b1;
        return;
      end

      r.has_scheme = f_scheme;
      r.has_domain = f_domain;
      r.has_port_part = f_port;
      r.has_path_part = f_path;
      r.scheme_len = f_scheme ? colon_pos : '0;
      r.domain_start = dom_b;
      r.domain_len = span_len(dom_b, dom_e);
      r.port_start = f_port ? port_b : '0;
      r.port_len = f_port ? span_len(port_b, port_e) : '0;
      r.path_start = f_path ? path_b : '0;
      r.path_len = f_path ? span_len(path_b, pos) : '0;
      r.overflow = f_ovf;
      if (f_ovf) n_overflow++;
      pending.push_back(r);
      restart();
    endfunction

    function void cmp(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: result beat with no URL pending, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      cmp("has_scheme", POS_W'(e.has_scheme), POS_W'(got.has_scheme));
      cmp("has_domain", POS_W'(e.has_domain), POS_W'(got.has_domain));
      cmp("has_port_part", POS_W'(e.has_port_part), POS_W'(got.has_port_part));
      cmp("has_path_part", POS_W'(e.has_path_part), POS_W'(got.has_path_part));
      cmp("scheme_len", e.scheme_len, got.scheme_len);
      cmp("domain_start", e.domain_start, got.domain_start);
      cmp("domain_len", e.domain_len, got.domain_len);
      cmp("port_start", e.port_start, got.port_start);
      cmp("port_len", e.port_len, got.port_len);
      cmp("path_start", e.path_start, got.path_start);
      cmp("path_len", e.path_len, got.path_len);
      cmp("overflow", POS_W'(e.overflow), POS_W'(got.overflow));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CH_W-1:0] ch = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic has_scheme, has_domain, has_port_part, has_path_part;
  logic [POS_W-1:0] scheme_len, domain_start, domain_len;
  logic [POS_W-1:0] port_start, port_len, path_start, path_len;
  logic overflow;
  res_t got;

  url_scoreboard sb = new();
  logic [CH_W-1:0] url_q[$];
  bit quiet = 0;
  int n_urls = 0;
  int n_bytes = 0;
  int n_short_bytes = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  assign got = {has_scheme, has_domain, has_port_part, has_path_part, scheme_len,
                domain_start, domain_len, port_start, port_len, path_start, path_len,
                overflow};

  url_component_splitter i_dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(ch);
      if (out_valid && out_ready) sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CH_W-1:0] text_byte();
    logic [CH_W-1:0] b;
    do b = CH_W'($urandom_range(1, 255));
    while (b == CH_COLON || b == CH_SLASH);
    return b;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) url_q.push_back(s[i]);
  endfunction

  task automatic send_byte(logic [CH_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= b;
    do @(posedge clk);
    while (!in_ready);
    n_bytes++;
  endtask

  task automatic send_url(bit counted);
    foreach (url_q[i]) send_byte(url_q[i]);
    if (counted) n_short_bytes += url_q.size();
    url_q.delete();
    n_urls++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk);
    while (sb.pending.size() != 0);
  endtask

  function automatic void build_random_url();
    int r;
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(0, 6)) url_q.push_back(text_byte());
        push_text("://");
      end
      repeat ($urandom_range(0, 12)) url_q.push_back(text_byte());
      if ($urandom_range(0, 2) == 0) begin
        url_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 5)) url_q.push_back(CH_W'(8'h30 + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1)) begin
        url_q.push_back(CH_SLASH);
        repeat ($urandom_range(0, 15)) begin
          r = $urandom_range(0, 19);
          url_q.push_back(r == 0 ? CH_COLON : r == 1 ? CH_SLASH : text_byte());
        end
      end
    end else begin
      repeat ($urandom_range(0, 12)) begin
        r = $urandom_range(0, 9);
        url_q.push_back(r < 3 ? CH_COLON : r < 6 ? CH_SLASH : text_byte());
      end
    end
    url_q.push_back(CH_END);
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_text("a://b:9/p");
    url_q.push_back(CH_END);
    send_url(0);
    push_text("h:/x");
    url_q.push_back(CH_END);
    send_url(0);
    push_text(":");
    url_q.push_back(CH_END);
    send_url(0);
    push_text("q:/");
    url_q.push_back(CH_END);
    send_url(0);
    url_q.push_back(CH_END);
    send_url(0);
    url_q.push_back(8'hFF);
    url_q.push_back(CH_SLASH);
    url_q.push_back(CH_END);
    send_url(0);
    wait_drained();

    while (n_short_bytes < RANDOM_BYTES) begin
      quiet = (n_urls % 9 == 4);
      build_random_url();
      send_url(1);
      if (n_urls == 20) wait_drained();
    end
    quiet = 0;

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d URLs in %0d bytes, %0d of them overflowing the buffer.",
             n_urls, n_bytes, sb.n_overflow);
    $display("Checked %0d results, %0d mismatches.", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
